@@ rtl/hpdc_pkg.sv @@
// Shared types, register codes and helpers for the head pointer dwell-click block.
// No dependencies; every other file refers to it by scoped names.
package hpdc_pkg;

  localparam int TDATA_IN_W  = 40;
  localparam int TDATA_OUT_W = 40;

  // dwell re-arm interval after a click, in ms
  localparam logic [16:0] REARM_MS = 17'd1000;

  typedef enum logic [2:0] {
    REG_GAIN_X        = 3'd0,
    REG_GAIN_Y        = 3'd1,
    REG_DAMPING       = 3'd2,
    REG_CENTER_X      = 3'd3,
    REG_CENTER_Y      = 3'd4,
    REG_DWELL_RADIUS  = 3'd5,
    REG_DWELL_TIME_MS = 3'd6,
    REG_MODE_FLAGS    = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [11:0] gain_x;
    logic [11:0] gain_y;
    logic [8:0]  damping;
    logic [12:0] screen_center_x;
    logic [12:0] screen_center_y;
    logic [9:0]  dwell_radius;
    logic [15:0] dwell_time_ms;
    logic [1:0]  mode_flags;
  } cfg_t;

  typedef struct packed {
    logic [11:0] feature_x;
    logic [11:0] feature_y;
    logic        key_toggle;
    logic        restart_request;
    logic [9:0]  delta_ms;
  } item_t;

  typedef struct packed {
    logic               move_valid;
    logic signed [15:0] pointer_x;
    logic signed [15:0] pointer_y;
    logic               click;
    logic               control_active;
  } result_t;

  // one strobe per datapath step
  typedef struct packed {
    logic load;
    logic mul;
    logic target;
    logic blend_mul;
    logic pointer;
    logic square;
    logic commit;
  } cmd_t;

  function automatic logic signed [15:0] sat16(input logic signed [27:0] v);
    logic signed [15:0] r;
    if (v > 28'sd32767) r = 16'sh7FFF;
    else if (v < -28'sd32768) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

endpackage

@@ rtl/hpdc_ctrl.sv @@
// Sequencing controller: steps the datapath through one item and owns the result valid flag.
// Depends on hpdc_pkg for the command struct.
module hpdc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output hpdc_pkg::cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_TARGET,
    ST_BLEND,
    ST_POINTER,
    ST_SQUARE,
    ST_DONE
  } state_t;

  state_t state;
  logic   slot_free;

  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == ST_IDLE);

  always_comb begin
    cmd           = '0;
    cmd.load      = (state == ST_IDLE) && in_valid;
    cmd.mul       = (state == ST_MUL);
    cmd.target    = (state == ST_TARGET);
    cmd.blend_mul = (state == ST_BLEND);
    cmd.pointer   = (state == ST_POINTER);
    cmd.square    = (state == ST_SQUARE);
    cmd.commit    = (state == ST_DONE) && slot_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.commit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (state)
        ST_IDLE:    if (in_valid) state <= ST_MUL;
        ST_MUL:     state <= ST_TARGET;
        ST_TARGET:  state <= ST_BLEND;
        ST_BLEND:   state <= ST_POINTER;
        ST_POINTER: state <= ST_SQUARE;
        ST_SQUARE:  state <= ST_DONE;
        ST_DONE: begin
          if (slot_free) state <= ST_IDLE;
        end
        default:    state <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/hpdc_dp.sv @@
// Datapath: control flags, reference latch, gain/blend arithmetic, dwell timer and result register.
// Depends on hpdc_pkg; driven by strobes from hpdc_ctrl.
module hpdc_dp (
  input  logic                clk,
  input  logic                rst,
  input  hpdc_pkg::cmd_t      cmd,
  input  hpdc_pkg::cfg_t      cfg,
  input  hpdc_pkg::item_t     item,
  output hpdc_pkg::result_t   result
);

  // architectural state
  logic               control_on;
  logic               relatch_pending;
  logic               reference_valid;
  logic [11:0]        reference_x;
  logic [11:0]        reference_y;
  logic               last_pointer_valid;
  logic signed [15:0] last_pointer_x;
  logic signed [15:0] last_pointer_y;
  logic signed [15:0] dwell_anchor_x;
  logic signed [15:0] dwell_anchor_y;
  logic [15:0]        dwell_timer_ms;
  logic               clicked_last;

  // per-item working registers
  logic [11:0]        feat_x;
  logic [11:0]        feat_y;
  logic [15:0]        elapsed;
  logic               active;
  logic signed [25:0] prod_x;
  logic signed [25:0] prod_y;
  logic signed [15:0] target_x;
  logic signed [15:0] target_y;
  logic signed [26:0] bprod_x;
  logic signed [26:0] bprod_y;
  logic signed [15:0] ptr_x;
  logic signed [15:0] ptr_y;
  logic signed [33:0] dsq_x;
  logic signed [33:0] dsq_y;
  logic [19:0]        rsq;

  // load-step combinational values
  logic        pend_next;
  logic        ctrl_next;
  logic        latch_ref;
  logic [16:0] elapsed_sum;

  // arithmetic helpers
  logic signed [12:0] diff_x;
  logic signed [12:0] diff_y;
  logic signed [26:0] disp_x;
  logic signed [26:0] disp_y;
  logic signed [15:0] tgt_x_w;
  logic signed [15:0] tgt_y_w;
  logic [8:0]         dsel;
  logic signed [16:0] bdiff_x;
  logic signed [16:0] bdiff_y;
  logic signed [15:0] blend_x_w;
  logic signed [15:0] blend_y_w;
  logic signed [16:0] dx;
  logic signed [16:0] dy;
  logic [34:0]        dist_sq;
  logic               outside;
  logic [16:0]        rearm_at;

  // dwell decision
  logic               cl_tmp;
  logic               click_w;
  logic               cl_next;
  logic [15:0]        timer_next;

  always_comb begin
    pend_next = relatch_pending | item.restart_request;
    ctrl_next = control_on ^ item.key_toggle;
    if (item.key_toggle && ctrl_next) pend_next = 1'b1;
    latch_ref   = ctrl_next && pend_next;
    elapsed_sum = 17'(dwell_timer_ms) + 17'(item.delta_ms);
  end

  always_comb begin
    diff_x  = $signed({1'b0, feat_x}) - $signed({1'b0, reference_x});
    diff_y  = $signed({1'b0, feat_y}) - $signed({1'b0, reference_y});
    disp_x  = cfg.mode_flags[0] ? -27'(prod_x) : 27'(prod_x);
    disp_y  = 27'(prod_y);
    tgt_x_w = hpdc_pkg::sat16(((28'(disp_x) + 28'sd128) >>> 8)
                              + $signed(28'(cfg.screen_center_x)));
    tgt_y_w = hpdc_pkg::sat16(((28'(disp_y) + 28'sd128) >>> 8)
                              + $signed(28'(cfg.screen_center_y)));
    dsel    = (cfg.damping > 9'd256) ? 9'd256 : cfg.damping;
    // target*d + last*(256-d) == last*256 + (target-last)*d
    bdiff_x   = 17'(target_x) - 17'(last_pointer_x);
    bdiff_y   = 17'(target_y) - 17'(last_pointer_y);
    blend_x_w = hpdc_pkg::sat16(((28'(bprod_x) + 28'sd128) >>> 8) + 28'(last_pointer_x));
    blend_y_w = hpdc_pkg::sat16(((28'(bprod_y) + 28'sd128) >>> 8) + 28'(last_pointer_y));
    dx = 17'(ptr_x) - 17'(dwell_anchor_x);
    dy = 17'(ptr_y) - 17'(dwell_anchor_y);
  end

  always_comb begin
    dist_sq  = 35'($unsigned(dsq_x)) + 35'($unsigned(dsq_y));
    outside  = dist_sq > 35'(rsq);
    rearm_at = 17'(cfg.dwell_time_ms) + hpdc_pkg::REARM_MS;
    cl_tmp     = outside ? 1'b0 : clicked_last;
    timer_next = outside ? 16'd0 : elapsed;
    click_w    = 1'b0;
    cl_next    = cl_tmp;
    if (elapsed >= cfg.dwell_time_ms && !cl_tmp) begin
      click_w = 1'b1;
      cl_next = 1'b1;
    end else if (17'(elapsed) >= rearm_at && cl_tmp) begin
      timer_next = 16'd0;
      cl_next    = 1'b0;
    end
  end

  // control and dwell state
  always_ff @(posedge clk) begin
    if (rst) begin
      control_on         <= 1'b0;
      relatch_pending    <= 1'b1;
      reference_valid    <= 1'b0;
      reference_x        <= '0;
      reference_y        <= '0;
      last_pointer_valid <= 1'b0;
      last_pointer_x     <= '0;
      last_pointer_y     <= '0;
      dwell_anchor_x     <= '0;
      dwell_anchor_y     <= '0;
      dwell_timer_ms     <= '0;
      clicked_last       <= 1'b0;
    end else begin
      if (cmd.load) begin
        control_on      <= ctrl_next;
        relatch_pending <= pend_next && !latch_ref;
        if (latch_ref) begin
          reference_x     <= item.feature_x;
          reference_y     <= item.feature_y;
          reference_valid <= 1'b1;
        end
      end
      if (cmd.commit) begin
        if (!active) begin
          dwell_timer_ms <= '0;
        end else begin
          last_pointer_valid <= 1'b1;
          last_pointer_x     <= ptr_x;
          last_pointer_y     <= ptr_y;
          if (cfg.mode_flags[1]) begin
            if (outside) begin
              dwell_anchor_x <= ptr_x;
              dwell_anchor_y <= ptr_y;
            end
            dwell_timer_ms <= timer_next;
            clicked_last   <= cl_next;
          end else begin
            dwell_timer_ms <= '0;
          end
        end
      end
    end
  end

  // working registers and result payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      feat_x  <= item.feature_x;
      feat_y  <= item.feature_y;
      elapsed <= elapsed_sum[16] ? 16'hFFFF : elapsed_sum[15:0];
      active  <= ctrl_next && (reference_valid || latch_ref);
    end
    if (cmd.mul) begin
      prod_x <= diff_x * $signed({1'b0, cfg.gain_x});
      prod_y <= diff_y * $signed({1'b0, cfg.gain_y});
    end
    if (cmd.target) begin
      target_x <= tgt_x_w;
      target_y <= tgt_y_w;
    end
    if (cmd.blend_mul) begin
      bprod_x <= bdiff_x * $signed({1'b0, dsel});
      bprod_y <= bdiff_y * $signed({1'b0, dsel});
    end
    if (cmd.pointer) begin
      ptr_x <= last_pointer_valid ? blend_x_w : target_x;
      ptr_y <= last_pointer_valid ? blend_y_w : target_y;
    end
    if (cmd.square) begin
      dsq_x <= dx * dx;
      dsq_y <= dy * dy;
      rsq   <= cfg.dwell_radius * cfg.dwell_radius;
    end
    if (cmd.commit) begin
      result.control_active <= control_on;
      result.move_valid     <= active;
      result.pointer_x      <= active ? ptr_x : 16'sd0;
      result.pointer_y      <= active ? ptr_y : 16'sd0;
      result.click          <= active && cfg.mode_flags[1] && click_w;
    end
  end

endmodule

@@ rtl/head_pointer_dwell_click.sv @@
// Top level of the head pointer dwell-click block: ports, register file, packing, checks.
// Depends on hpdc_pkg, hpdc_ctrl and hpdc_dp.
//
//  channel | direction | handshake           | payload
//  s       | in        | s_tvalid / s_tready | s_tdata  feature, flags, delta_ms
//  m       | out       | m_tvalid / m_tready | m_tdata  pointer, click, control state
//  cfg     | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// Each item passes through the load step at acceptance, then six steps of the
// datapath sequencer (gain multiply, target, blend multiply, pointer, distance
// square, commit). The result register is loaded in the commit step and the
// next item can be taken on the following cycle, even while the previous result
// waits in the output register. A stalled output holds the sequencer in its commit
// step. Synchronous reset restores the register defaults and clears all tracking
// state; no clearing pass.
module head_pointer_dwell_click (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [11:0] feature_x, [23:12] feature_y, [24] key_toggle,
  // [25] restart_request, [35:26] delta_ms, [39:36] zero
  input  logic [hpdc_pkg::TDATA_IN_W-1:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [0] move_valid, [16:1] pointer_x, [32:17] pointer_y,
  // [33] click, [34] control_active, [39:35] zero
  output logic [hpdc_pkg::TDATA_OUT_W-1:0] m_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  hpdc_pkg::cfg_t    cfg;
  hpdc_pkg::item_t   item;
  hpdc_pkg::result_t result;
  hpdc_pkg::cmd_t    cmd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_x          <= 12'd256;
      cfg.gain_y          <= 12'd256;
      cfg.damping         <= 9'd128;
      cfg.screen_center_x <= 13'd960;
      cfg.screen_center_y <= 13'd540;
      cfg.dwell_radius    <= 10'd20;
      cfg.dwell_time_ms   <= 16'd1000;
      cfg.mode_flags      <= 2'd2;
    end else if (cfg_valid) begin
      case (hpdc_pkg::cfg_idx_t'(cfg_index))
        hpdc_pkg::REG_GAIN_X:        cfg.gain_x          <= cfg_data[11:0];
        hpdc_pkg::REG_GAIN_Y:        cfg.gain_y          <= cfg_data[11:0];
        hpdc_pkg::REG_DAMPING:       cfg.damping         <= cfg_data[8:0];
        hpdc_pkg::REG_CENTER_X:      cfg.screen_center_x <= cfg_data[12:0];
        hpdc_pkg::REG_CENTER_Y:      cfg.screen_center_y <= cfg_data[12:0];
        hpdc_pkg::REG_DWELL_RADIUS:  cfg.dwell_radius    <= cfg_data[9:0];
        hpdc_pkg::REG_DWELL_TIME_MS: cfg.dwell_time_ms   <= cfg_data;
        hpdc_pkg::REG_MODE_FLAGS:    cfg.mode_flags      <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  assign item.feature_x       = s_tdata[11:0];
  assign item.feature_y       = s_tdata[23:12];
  assign item.key_toggle      = s_tdata[24];
  assign item.restart_request = s_tdata[25];
  assign item.delta_ms        = s_tdata[35:26];

  hpdc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .cmd       (cmd)
  );

  hpdc_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .cfg    (cfg),
    .item   (item),
    .result (result)
  );

  assign m_tdata = {5'd0, result.control_active, result.click, result.pointer_y,
                    result.pointer_x, result.move_valid};

  // one item in flight: acceptance closes the input until the sequencer returns
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while an item is in flight");

  a_click_needs_move: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[33] |-> m_tdata[0])
    else $error("click without a pointer position");

  a_move_needs_control: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> m_tdata[34])
    else $error("pointer position given while control is off");

endmodule
